>>> rtl/core/avsd_pkg.sv
// ---------------------------------------------------------------------------
// avsd_pkg
// Shared widths, codes and the command type passed from the tick front end
// to the speed/direction back end.
// ---------------------------------------------------------------------------
package avsd_pkg;

    // Field widths.
    localparam int SPEED_W = 24;
    localparam int EDGE_W  = 8;
    localparam int TIMER_W = 16;
    localparam int ADC_W   = 12;
    localparam int DIR_W   = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIRCUMFERENCE = 2'd0,
        CFG_EDGES         = 2'd1,
        CFG_DIR_INTERVAL  = 2'd2
    } t_cfg_idx;

    // Register reset values.
    localparam logic [SPEED_W-1:0] CIRC_RESET     = 24'd565200;
    localparam logic [EDGE_W-1:0]  EDGES_RESET    = 8'd4;
    localparam logic [TIMER_W-1:0] INTERVAL_RESET = 16'd5000;

    // Saturation limits.
    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [SPEED_W-1:0] ELAPSED_MAX = {SPEED_W{1'b1}};
    localparam logic [TIMER_W-1:0] TIMER_MAX   = {TIMER_W{1'b1}};

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_W_CODE = 4'd0;
    localparam logic [DIR_W-1:0] DIR_NW     = 4'd1;
    localparam logic [DIR_W-1:0] DIR_N      = 4'd2;
    localparam logic [DIR_W-1:0] DIR_SW     = 4'd3;
    localparam logic [DIR_W-1:0] DIR_NE     = 4'd4;
    localparam logic [DIR_W-1:0] DIR_S      = 4'd5;
    localparam logic [DIR_W-1:0] DIR_SE     = 4'd6;
    localparam logic [DIR_W-1:0] DIR_E      = 4'd7;
    localparam logic [DIR_W-1:0] DIR_NONE   = 4'd8;

    // Vane band thresholds.
    localparam logic [ADC_W-1:0] BAND_W_HI  = 12'd450;
    localparam logic [ADC_W-1:0] BAND_NW_HI = 12'd650;
    localparam logic [ADC_W-1:0] BAND_N_HI  = 12'd875;
    localparam logic [ADC_W-1:0] BAND_SW_HI = 12'd1050;
    localparam logic [ADC_W-1:0] BAND_NE_HI = 12'd1300;
    localparam logic [ADC_W-1:0] BAND_S_HI  = 12'd1750;
    localparam logic [ADC_W-1:0] BAND_SE_HI = 12'd2500;
    localparam logic [ADC_W-1:0] BAND_E_HI  = 12'd3500;

    // Divider step count and its counter width.
    localparam int DIV_STEPS = SPEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Default depth of the command queue.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Work handed from front to back for one tick.
    typedef struct packed {
        logic               speed_valid;
        logic               speed_div;
        logic [SPEED_W-1:0] numer;
        logic [SPEED_W-1:0] denom;
        logic               dir_valid;
        logic [DIR_W-1:0]   dir_code;
    } t_cmd;

    // Maps a vane reading to its sector. Zero lands in the NW band.
    function automatic logic [DIR_W-1:0] classify_dir(input logic [ADC_W-1:0] adc);
        logic [DIR_W-1:0] code;
        if (adc != '0 && adc < BAND_W_HI)  code = DIR_W_CODE;
        else if (adc < BAND_NW_HI)         code = DIR_NW;
        else if (adc < BAND_N_HI)          code = DIR_N;
        else if (adc < BAND_SW_HI)         code = DIR_SW;
        else if (adc < BAND_NE_HI)         code = DIR_NE;
        else if (adc < BAND_S_HI)          code = DIR_S;
        else if (adc < BAND_SE_HI)         code = DIR_SE;
        else if (adc < BAND_E_HI)          code = DIR_E;
        else                               code = DIR_NONE;
        return code;
    endfunction

endpackage

>>> rtl/core/avsd_front.sv
// ---------------------------------------------------------------------------
// avsd_front
// Takes one tick per cycle while the queue has room, tracks pin edges, round
// time and the direction timer, and queues the tick's command for the back end.
// ---------------------------------------------------------------------------
module avsd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration writes.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [avsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [avsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Tick stream: [0] speed_pin_level, [12:1] vane_adc_sample.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,
    // Command queue write side.
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output avsd_pkg::t_cmd               o_cmd
);
    import avsd_pkg::*;

    logic [SPEED_W-1:0] r_circ;
    logic [EDGE_W-1:0]  r_edges;
    logic [TIMER_W-1:0] r_interval;

    logic               r_prev_level;
    logic [EDGE_W-1:0]  r_edge_cnt;
    logic [SPEED_W-1:0] r_elapsed;
    logic [TIMER_W-1:0] r_dir_timer;

    logic               n_prev_level;
    logic [EDGE_W-1:0]  n_edge_cnt;
    logic [SPEED_W-1:0] n_elapsed;
    logic [TIMER_W-1:0] n_dir_timer;

    logic               level;
    logic [ADC_W-1:0]   adc;
    logic               pin_edge;
    logic [EDGE_W:0]    edge_sum;
    logic               round_done;
    logic [SPEED_W-1:0] elapsed_inc;
    logic               dir_sample;
    logic               accept;

    assign level  = s_axis_tdata[0];
    assign adc    = s_axis_tdata[ADC_W:1];
    assign accept = s_axis_tvalid && i_cmd_ready;

    assign s_axis_tready = i_cmd_ready;
    assign o_cfg_ready   = 1'b1;
    assign o_cmd_valid   = s_axis_tvalid;

    // Round tracking: time advances while a round is open, and the first
    // edge restarts it.
    always_comb begin
        elapsed_inc = r_elapsed;
        if (r_edge_cnt != '0 && r_elapsed != ELAPSED_MAX) begin
            elapsed_inc = r_elapsed + 1'b1;
        end
        pin_edge   = level != r_prev_level;
        edge_sum   = {1'b0, r_edge_cnt} + 1'b1;
        round_done = pin_edge && (edge_sum[EDGE_W] || edge_sum[EDGE_W-1:0] >= r_edges);
        n_elapsed  = (pin_edge && r_edge_cnt == '0) ? '0 : elapsed_inc;
        n_edge_cnt = r_edge_cnt;
        if (pin_edge) begin
            n_edge_cnt = round_done ? '0 : edge_sum[EDGE_W-1:0];
        end
        n_prev_level = level;
    end

    // Direction timer: sample once it has reached the interval.
    always_comb begin
        dir_sample  = r_dir_timer >= r_interval;
        n_dir_timer = r_dir_timer;
        if (dir_sample) begin
            n_dir_timer = '0;
        end else if (r_dir_timer != TIMER_MAX) begin
            n_dir_timer = r_dir_timer + 1'b1;
        end
    end

    // Command for this tick.
    always_comb begin
        o_cmd.speed_valid = round_done;
        o_cmd.speed_div   = round_done && n_elapsed != '0;
        o_cmd.numer       = r_circ;
        o_cmd.denom       = n_elapsed;
        o_cmd.dir_valid   = dir_sample;
        o_cmd.dir_code    = dir_sample ? classify_dir(adc) : DIR_NONE;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ     <= CIRC_RESET;
            r_edges    <= EDGES_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CIRCUMFERENCE: r_circ     <= i_cfg_data[SPEED_W-1:0];
                CFG_EDGES:         r_edges    <= i_cfg_data[EDGE_W-1:0];
                CFG_DIR_INTERVAL:  r_interval <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_edge_cnt   <= '0;
            r_elapsed    <= '0;
            r_dir_timer  <= '0;
        end else if (accept) begin
            r_prev_level <= n_prev_level;
            r_edge_cnt   <= n_edge_cnt;
            r_elapsed    <= n_elapsed;
            r_dir_timer  <= n_dir_timer;
        end
    end

endmodule

>>> rtl/core/avsd_fifo.sv
// ---------------------------------------------------------------------------
// avsd_fifo
// Short command queue that lets the front end keep taking ticks while the
// back end is dividing.
// ---------------------------------------------------------------------------
module avsd_fifo #(
    parameter int DEPTH = avsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  avsd_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output avsd_pkg::t_cmd o_pop_cmd
);
    import avsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != FULL;
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("command queue count exceeds depth");

    // A push without a pop leaves something to read.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> o_pop_valid)
        else $error("command queue empty after push");

endmodule

>>> rtl/core/avsd_back.sv
// ---------------------------------------------------------------------------
// avsd_back
// Pops commands, divides circumference by round time one quotient bit per
// cycle, and holds each result in an output register until taken.
// ---------------------------------------------------------------------------
module avsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  avsd_pkg::t_cmd i_cmd,
    // Results: [0] speed_valid, [24:1] speed_mm_per_s, [25] direction_valid,
    // [29:26] direction_code.
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [31:0]    m_axis_tdata
);
    import avsd_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [SPEED_W-1:0]   r_rem;
    logic [SPEED_W-1:0]   r_quo;
    logic [SPEED_W-1:0]   r_denom;
    logic                 r_speed_valid;
    logic                 r_speed_div;
    logic                 r_dir_valid;
    logic [DIR_W-1:0]     r_dir_code;

    logic                 r_out_valid;
    logic [31:0]          r_out_data;

    logic [SPEED_W:0]     trial;
    logic                 trial_ok;
    logic [SPEED_W-1:0]   speed;
    logic                 out_free;
    logic                 finish;
    logic                 take;

    assign o_cmd_ready   = !r_busy;
    assign take          = i_cmd_valid && !r_busy;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign finish        = r_busy && r_div_cnt == '0 && out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // One restoring divide step.
    always_comb begin
        trial    = {r_rem, r_quo[SPEED_W-1]} - {1'b0, r_denom};
        trial_ok = !trial[SPEED_W];
    end

    // Final speed: quotient, or saturated for a zero-time round.
    always_comb begin
        if (r_speed_div) begin
            speed = r_quo;
        end else if (r_speed_valid) begin
            speed = SPEED_MAX;
        end else begin
            speed = '0;
        end
    end

    // Command capture and divider iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_div_cnt <= '0;
        end else if (take) begin
            r_busy    <= 1'b1;
            r_div_cnt <= i_cmd.speed_div ? DIV_CNT_W'(DIV_STEPS) : '0;
        end else if (r_busy && r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end else if (finish) begin
            r_busy <= 1'b0;
        end
    end

    // Divider datapath and held command fields.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rem         <= '0;
            r_quo         <= i_cmd.numer;
            r_denom       <= i_cmd.denom;
            r_speed_valid <= i_cmd.speed_valid;
            r_speed_div   <= i_cmd.speed_div;
            r_dir_valid   <= i_cmd.dir_valid;
            r_dir_code    <= i_cmd.dir_code;
        end else if (r_busy && r_div_cnt != '0) begin
            r_rem <= trial_ok ? trial[SPEED_W-1:0] : {r_rem[SPEED_W-2:0], r_quo[SPEED_W-1]};
            r_quo <= {r_quo[SPEED_W-2:0], trial_ok};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= {2'b00, r_dir_code, r_dir_valid, speed, r_speed_valid};
        end
    end

    // The step counter runs only while a command is held.
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |-> (r_busy && r_div_cnt <= DIV_CNT_W'(DIV_STEPS)))
        else $error("divider counting without a command");

    // Finishing always presents a result next cycle.
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_out_valid && !r_busy))
        else $error("finished command did not reach the output register");

endmodule

>>> rtl/core/anemometer_speed_and_vane_direction_top.sv
// ---------------------------------------------------------------------------
// anemometer_speed_and_vane_direction_top
// Cup anemometer round speed and wind vane sector from millisecond ticks.
// ---------------------------------------------------------------------------
// Each input item is one millisecond tick and yields exactly one result item.
// The front end takes a tick every cycle while the command queue has room and
// queues one command per tick. The back end takes one command at a time and
// holds it until its result is registered; a tick that completes a round with
// nonzero time runs the radix-2 divider (24 quotient bits, one per cycle)
// that forms circumference / elapsed ms. Configuration writes are always
// accepted and should be made while no result is outstanding.
module anemometer_speed_and_vane_direction_top #(
    parameter int QUEUE_DEPTH = avsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [avsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [avsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] speed_pin_level, [12:1] vane_adc_sample, [15:13] zero.
    input  logic [15:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] speed_valid, [24:1] speed_mm_per_s, [25] direction_valid,
    // [29:26] direction_code, [31:30] zero.
    output logic [31:0]                     m_axis_tdata
);
    import avsd_pkg::*;

    logic cmd_in_valid;
    logic cmd_in_ready;
    t_cmd cmd_in;
    logic cmd_out_valid;
    logic cmd_out_ready;
    t_cmd cmd_out;

    // Tick classification and state tracking.
    avsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_cmd_valid   (cmd_in_valid),
        .i_cmd_ready   (cmd_in_ready),
        .o_cmd         (cmd_in)
    );

    // Decoupling queue.
    avsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_in_valid),
        .o_push_ready (cmd_in_ready),
        .i_push_cmd   (cmd_in),
        .o_pop_valid  (cmd_out_valid),
        .i_pop_ready  (cmd_out_ready),
        .o_pop_cmd    (cmd_out)
    );

    // Speed division and result output.
    avsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_out_valid),
        .o_cmd_ready   (cmd_out_ready),
        .i_cmd         (cmd_out),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> verif/avsd_tick_checker.sv
// ----------------------------------------------------------------------------
// avsd_tick_checker
// Watches the configuration, tick and result channels of the anemometer block.
// For every accepted tick it works out the expected speed and vane result.
// It then compares each accepted result field by field with the oldest
// expectation, and reports the failure count and the expectations still open.
// ----------------------------------------------------------------------------
module avsd_tick_checker
    import avsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [0] speed_pin_level, [12:1] vane_adc_sample, [15:13] zero.
    input  logic [15:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] speed_valid, [24:1] speed_mm_per_s, [25] direction_valid,
    // [29:26] direction_code, [31:30] zero.
    input  logic [31:0]           m_axis_tdata,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result item laid out as it travels on the result bus.
    typedef struct packed {
        logic [1:0]         pad;
        logic [DIR_W-1:0]   dir_code;
        logic               dir_valid;
        logic [SPEED_W-1:0] speed;
        logic               speed_valid;
    } t_tick_result;

    // Register copies.
    logic [SPEED_W-1:0] circ_um;
    logic [EDGE_W-1:0]  edges_cfg;
    logic [TIMER_W-1:0] vane_interval;

    // Measurement state.
    logic               pin_last;
    logic [EDGE_W-1:0]  edges_seen;
    logic [SPEED_W-1:0] round_ms;
    logic [TIMER_W-1:0] vane_timer;

    t_tick_result tick_results_due[$];
    int           reported;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        reported      = 0;
    end

    // Sector of a vane reading; the narrowest band that holds it wins, and a
    // reading of zero belongs to the northwest band.
    function automatic logic [DIR_W-1:0] vane_sector(input logic [ADC_W-1:0] adc);
        logic [DIR_W-1:0] code;
        code = DIR_NONE;
        if (adc < BAND_E_HI)  code = DIR_E;
        if (adc < BAND_SE_HI) code = DIR_SE;
        if (adc < BAND_S_HI)  code = DIR_S;
        if (adc < BAND_NE_HI) code = DIR_NE;
        if (adc < BAND_SW_HI) code = DIR_SW;
        if (adc < BAND_N_HI)  code = DIR_N;
        if (adc < BAND_NW_HI) code = DIR_NW;
        if (adc < BAND_W_HI)  code = DIR_W_CODE;
        if (adc == '0)        code = DIR_NW;
        return code;
    endfunction

    // Advances the measurement state by one tick and returns its result.
    function automatic t_tick_result predict_tick(input logic lvl,
                                                  input logic [ADC_W-1:0] adc);
        t_tick_result r;
        r             = '0;
        r.dir_code    = DIR_NONE;

        // A running round accumulates time, held at the top of its range.
        if (edges_seen != '0 && round_ms != ELAPSED_MAX)
            round_ms = round_ms + 1'b1;

        // Every pin level change is an edge; the first one restarts the clock.
        if (lvl != pin_last) begin
            if (edges_seen == '0)
                round_ms = '0;
            edges_seen = edges_seen + 1'b1;
            if (edges_seen == '0 || edges_seen >= edges_cfg) begin
                r.speed_valid = 1'b1;
                r.speed       = (round_ms == '0) ? SPEED_MAX : circ_um / round_ms;
                edges_seen    = '0;
            end
        end
        pin_last = lvl;

        // The vane is sampled once the timer has reached the interval.
        if (vane_timer >= vane_interval) begin
            vane_timer  = '0;
            r.dir_valid = 1'b1;
            r.dir_code  = vane_sector(adc);
        end else if (vane_timer != TIMER_MAX) begin
            vane_timer = vane_timer + 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tick_result seen;
        t_tick_result due;
        if (!i_rst_n) begin
            circ_um       = CIRC_RESET;
            edges_cfg     = EDGES_RESET;
            vane_interval = INTERVAL_RESET;
            pin_last      = 1'b0;
            edges_seen    = '0;
            round_ms      = '0;
            vane_timer    = '0;
            tick_results_due.delete();
        end else begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CIRCUMFERENCE: circ_um       = i_cfg_data[SPEED_W-1:0];
                    CFG_EDGES:         edges_cfg     = i_cfg_data[EDGE_W-1:0];
                    CFG_DIR_INTERVAL:  vane_interval = i_cfg_data[TIMER_W-1:0];
                    default: ;
                endcase
            end

            // Each accepted tick yields exactly one expected result.
            if (s_axis_tvalid && s_axis_tready)
                tick_results_due.push_back(predict_tick(s_axis_tdata[0],
                                                        s_axis_tdata[ADC_W:1]));

            // Compare each result item with the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                seen = t_tick_result'(m_axis_tdata);
                if (tick_results_due.size() == 0) begin
                    o_fail_count++;
                    if (reported < 10)
                        $display("%0t: result item with no tick waiting: %h",
                                 $realtime, m_axis_tdata);
                    reported++;
                end else begin
                    due = tick_results_due.pop_front();
                    if (seen.speed_valid != due.speed_valid || seen.speed != due.speed ||
                        seen.dir_valid != due.dir_valid || seen.dir_code != due.dir_code)
                    begin
                        o_fail_count++;
                        if (reported < 10)
                            $display({"%0t: mismatch: expected speed_valid=%0d speed=%0d ",
                                      "dir_valid=%0d dir=%0d, got speed_valid=%0d ",
                                      "speed=%0d dir_valid=%0d dir=%0d"},
                                     $realtime, due.speed_valid, due.speed,
                                     due.dir_valid, due.dir_code, seen.speed_valid,
                                     seen.speed, seen.dir_valid, seen.dir_code);
                        reported++;
                    end
                end
            end
        end
        o_outstanding = tick_results_due.size();
    end

endmodule

>>> verif/anemometer_speed_and_vane_direction_top_tb.sv
// ----------------------------------------------------------------------------
// anemometer_speed_and_vane_direction_top_tb
// Drives millisecond ticks into the anemometer and vane block.
// A directed opening walks every vane band edge, zero-time rounds, a zero
// edge count and an edge count lowered below a running round. Random phases
// follow under several register settings and idle patterns on both buses;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module anemometer_speed_and_vane_direction_top_tb;
    import avsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_TICKS   = 312;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;

    int fail_count;
    int outstanding;
    int sender_idle_pct = 38;
    int recv_idle_pct   = 48;
    logic pin_level = 1'b0;

    // Vane readings on both sides of every band edge, zero and full scale.
    int adc_marks [19] = '{0, 1, 449, 450, 649, 650, 874, 875, 1049, 1050,
                           1299, 1300, 1749, 1750, 2499, 2500, 3499, 3500, 4095};

    anemometer_speed_and_vane_direction_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    avsd_tick_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 50 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side back-pressure, redrawn every cycle.
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("[anemometer_speed_and_vane_direction_top] ERROR");
        $finish;
    end

    // Sends one tick; called at a falling edge and returns at one with valid high.
    task automatic send_tick(input logic flip, input logic [ADC_W-1:0] adc);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        pin_level      = pin_level ^ flip;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, adc, pin_level};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops ticks and waits until every result item has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [SPEED_W-1:0] circ,
                             input logic [EDGE_W-1:0]  edges,
                             input logic [TIMER_W-1:0] interval);
        drain();
        cfg_write(CFG_CIRCUMFERENCE, circ);
        cfg_write(CFG_EDGES, CFG_DATA_W'(edges));
        cfg_write(CFG_DIR_INTERVAL, CFG_DATA_W'(interval));
    endtask

    // One random phase: a register setting, then ticks with random vane data
    // and a pin that changes level at the given rate.
    task automatic random_phase(input logic [SPEED_W-1:0] circ,
                                input logic [EDGE_W-1:0]  edges,
                                input logic [TIMER_W-1:0] interval,
                                input int                 toggle_pct);
        configure(circ, edges, interval);
        repeat (PHASE_TICKS)
            send_tick($urandom_range(99) < toggle_pct, ADC_W'($urandom_range(4095)));
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every tick samples the vane and every edge closes a zero-time round.
        configure(SPEED_MAX, 8'd1, 16'd0);
        for (int k = 0; k < 19; k++)
            send_tick(k % 5 != 4, ADC_W'(adc_marks[k]));

        // An edge count of zero acts as one.
        configure(SPEED_MAX, 8'd0, 16'd0);
        send_tick(1'b1, 12'd700);
        send_tick(1'b1, 12'd0);

        // Lowering the edge count below a running round closes it on the next edge.
        configure(24'd1000, 8'd5, 16'd3);
        repeat (3) send_tick(1'b1, 12'd2000);
        drain();
        cfg_write(CFG_EDGES, 24'd2);
        send_tick(1'b0, 12'd3000);
        send_tick(1'b1, 12'd100);

        random_phase(24'($urandom_range(1, 16777215)), 8'($urandom_range(1, 6)),
                     16'($urandom_range(0, 15)), 40);
        random_phase(24'd1, 8'd255, 16'd65535, 90);

        sender_idle_pct = 48;
        recv_idle_pct   = 38;
        random_phase(SPEED_MAX, 8'd1, 16'd1, 20);
        random_phase(24'($urandom_range(1, 16777215)), 8'($urandom_range(2, 12)),
                     16'($urandom_range(0, 40)), 50);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        random_phase(CIRC_RESET, EDGES_RESET, 16'($urandom_range(0, 300)), 30);
        random_phase(24'($urandom_range(1, 16777215)), 8'd0, 16'd0, 60);

        drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("[anemometer_speed_and_vane_direction_top] OK");
        end else begin
            $display("[anemometer_speed_and_vane_direction_top] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/avsd_pkg.sv
rtl/core/avsd_front.sv
rtl/core/avsd_fifo.sv
rtl/core/avsd_back.sv
rtl/core/anemometer_speed_and_vane_direction_top.sv
verif/avsd_tick_checker.sv
verif/anemometer_speed_and_vane_direction_top_tb.sv
